>>> rtl/mtr_pkg.sv
// ----------------------------------------------------------------------------
// mtr_pkg
// Shared types, constants and helpers of the media timestamp repair unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mtr_pkg;

  localparam int unsigned DEF_NUM_STREAMS = 16;

  localparam int unsigned TS_W    = 64;  // timestamp width
  localparam int unsigned RATIO_W = 31;  // time base / frame rate term width
  localparam int unsigned PROD_W  = 2 * RATIO_W;
  localparam int unsigned DIVN_W  = PROD_W + 1;  // dividend, product plus half divisor
  localparam int unsigned DIVD_W  = PROD_W;      // divisor
  localparam int unsigned DUR_W   = DIVN_W;      // frame duration
  localparam int unsigned THR_W   = DUR_W + 7;   // duration times one hundred
  localparam int unsigned CNT_W   = 16;          // jump counter
  localparam int unsigned MASK_W  = 16;          // lossy stream mask
  localparam int unsigned SID_W   = 4;
  localparam int unsigned SINK_W  = 2;

  localparam logic [DUR_W-1:0]   DEFAULT_DURATION = DUR_W'(3000);
  localparam logic [RATIO_W-1:0] FALLBACK_FPS     = RATIO_W'(30);
  localparam logic [TS_W-1:0]    START_STAMP      = TS_W'(1);
  localparam logic [TS_W-1:0]    S64_MAX          = {1'b0, {(TS_W-1){1'b1}}};
  localparam logic [CNT_W-1:0]   CNT_MAX          = '1;

  localparam logic OP_PROCESS = 1'b0;
  localparam logic OP_RESET   = 1'b1;

  localparam logic [SINK_W-1:0] SINK_SEGMENT = 2'd0;
  localparam logic [SINK_W-1:0] SINK_FILE    = 2'd1;

  // Per-stream tracking record kept in the state RAM. A held last PTS is
  // marked by the entry valid flop outside the RAM.
  typedef struct packed {
    logic [TS_W-1:0]  prev_pts;
    logic [TS_W-1:0]  guess;
    logic             guess_valid;
    logic [CNT_W-1:0] jump_cnt;
  } stream_entry_t;

  localparam int unsigned ENTRY_W = $bits(stream_entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_MUL_C,
    S_MUL_B,
    S_ADD,
    S_DIV_GO,
    S_DIV,
    S_PSUM,
    S_FIX,
    S_DIFF,
    S_CMP10,
    S_CMP100,
    S_NEXT,
    S_WRB,
    S_FILL,
    S_OUT
  } mtr_state_e;

  // Add a non-negative duration, saturate at the largest signed value.
  function automatic logic [TS_W-1:0] sat_add(input logic [TS_W-1:0] a,
                                              input logic [DUR_W-1:0] d);
    logic [TS_W-1:0] s;
    s = a + TS_W'(d);
    if (!a[TS_W-1] && s[TS_W-1]) begin
      return S64_MAX;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mtr_ram.sv
// ----------------------------------------------------------------------------
// mtr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mtr_ram #(
  parameter int unsigned WIDTH = mtr_pkg::ENTRY_W,
  parameter int unsigned DEPTH = mtr_pkg::DEF_NUM_STREAMS,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/mtr_div.sv
// ----------------------------------------------------------------------------
// mtr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mtr_div #(
  parameter int unsigned NUM_W = mtr_pkg::DIVN_W,
  parameter int unsigned DEN_W = mtr_pkg::DIVD_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic      [NUM_W-1:0] quot_o
);

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W+1:0] trial;
  logic             fits;

  // shift in the next dividend bit, try the subtract
  assign trial = {1'b0, rem_q, quo_q[NUM_W-1]} - {2'b00, den_q};
  assign fits  = !trial[DEN_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], fits};
      rem_q <= fits ? trial[DEN_W-1:0] : {rem_q[DEN_W-2:0], quo_q[NUM_W-1]};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

>>> rtl/media_timestamp_repair_unit.sv
// Flow: a reset item gives its result in the cycle after the input transfer; a
//   packet on an untracked or non-lossy stream passes through load and fill; a
//   lossy packet with a default duration runs the repair states; when the
//   duration comes from the 63-step restoring divider, it sets the item rate.
// Throughput: one item at a time; the next is taken the cycle after the result
//   transfer. Reset clears the lossy mask and marks every stream record empty.
// ----------------------------------------------------------------------------
// media_timestamp_repair_unit
// Per-stream PTS/DTS repair: derives a frame duration with a shared multiplier
// and an iterative divider, fills missing stamps, tracks expected PTS and
// flags, counts and snaps large jumps. Stream records live in a small RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module media_timestamp_repair_unit #(
  parameter int unsigned NUM_STREAMS = mtr_pkg::DEF_NUM_STREAMS
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // configuration: lossy_stream_mask
  input  wire logic         cfg_we_i,
  input  wire logic [15:0]  cfg_wdata_i,
  // input stream
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // pts_in[63:0] pts_present[64] dts_in[128:65] dts_present[129]
  // tb_num[160:130] tb_den[191:161] rate_num[222:192] rate_den[253:223]
  input  wire logic [255:0] s_axis_tdata_i,
  // op[0] stream_id[4:1] sink_kind[6:5]
  input  wire logic [6:0]   s_axis_tuser_i,
  // result stream
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // pts_out[63:0] dts_out[127:64] jump_seen[128] jump_snapped[129]
  // jump_total[145:130] bad_sink[146]
  output logic [151:0]      m_axis_tdata_o
);

  import mtr_pkg::*;

  localparam int unsigned AW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  mtr_state_e              state_q, state_d;
  logic [MASK_W-1:0]       lossy_q;
  logic [NUM_STREAMS-1:0]  entry_valid_q;

  // latched item
  logic [SID_W-1:0]   sid_q;
  logic [AW-1:0]      sidx_q;
  logic               tracked_q, dur_full_q;
  logic [TS_W-1:0]    pts_q, dts_q;
  logic               pv_q, dv_q;
  logic [RATIO_W-1:0] tbn_q, tbd_q, rn_q, rd_q;
  logic [SINK_W-1:0]  sink_q;

  // stream record and working registers
  logic [TS_W-1:0]    prev_q, guess_q, psum_q, diff_q;
  logic               gv_q, pvalid_q;
  logic [CNT_W-1:0]   jcnt_q;
  logic [DIVN_W-1:0]  num_q;
  logic [DIVD_W-1:0]  den_q;
  logic [DUR_W-1:0]   fd_q;
  logic [THR_W-1:0]   thr_q;
  logic               seen_q, snap_q;

  // result register
  logic [TS_W-1:0]    o_pts_q, o_dts_q;
  logic               o_seen_q, o_snap_q, o_bad_q;
  logic [CNT_W-1:0]   o_total_q;

  // handshakes and decode of the incoming item
  logic               s_xfer, m_xfer;
  logic               in_op;
  logic [SID_W-1:0]   in_sid;
  logic [AW-1:0]      in_sidx;
  logic               in_tracked;

  assign s_xfer     = s_axis_tvalid_i && s_axis_tready_o;
  assign m_xfer     = m_axis_tvalid_o && m_axis_tready_i;
  assign in_op      = s_axis_tuser_i[0];
  assign in_sid     = s_axis_tuser_i[4:1];
  assign in_sidx    = AW'(in_sid);
  assign in_tracked = 32'(in_sid) < NUM_STREAMS;

  // --------------------------------------------------------------------------
  // Stream record RAM
  // --------------------------------------------------------------------------
  logic          ram_we, ram_re;
  stream_entry_t ram_wdata, ram_rdata, rec;
  logic [ENTRY_W-1:0] ram_rbits;

  assign ram_rdata = stream_entry_t'(ram_rbits);

  always_comb begin
    ram_wdata.prev_pts    = pts_q;
    ram_wdata.guess       = pvalid_q ? psum_q : '0;
    ram_wdata.guess_valid = pvalid_q;
    ram_wdata.jump_cnt    = jcnt_q;
  end

  mtr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_STREAMS),
    .AW    (AW)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (sidx_q),
    .wdata_i (ENTRY_W'(ram_wdata)),
    .re_i    (ram_re),
    .raddr_i (in_sidx),
    .rdata_o (ram_rbits)
  );

  // an empty record reads as all zeros
  logic rec_valid;
  assign rec_valid = tracked_q && entry_valid_q[sidx_q];
  assign rec       = rec_valid ? ram_rdata : '0;

  // --------------------------------------------------------------------------
  // Shared arithmetic: multiplier, divider, saturating adder
  // --------------------------------------------------------------------------
  logic [RATIO_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0]  mul_p;

  always_comb begin
    mul_a = rd_q;
    mul_b = tbd_q;
    if (state_q == S_MUL_C) begin
      mul_a = dur_full_q ? rn_q : tbn_q;
      mul_b = dur_full_q ? tbn_q : FALLBACK_FPS;
    end
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  logic              div_start, div_busy, div_done;
  logic [DIVN_W-1:0] div_quot;

  mtr_div #(
    .NUM_W (DIVN_W),
    .DEN_W (DIVD_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // one saturating adder: last PTS plus duration, then new PTS plus duration
  logic [TS_W-1:0] sat_sum;
  assign sat_sum = sat_add((state_q == S_PSUM) ? prev_q : pts_q, fd_q);

  logic lossy_hit;
  assign lossy_hit = tracked_q && lossy_q[sid_q];

  // usable time base: the duration comes from the divider
  logic tb_ok;
  assign tb_ok = (tbn_q != '0) && (tbd_q != '0);

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_xfer) begin
          state_d = (in_op == OP_RESET) ? S_OUT : S_LOAD;
        end
      end
      S_LOAD: begin
        if (!lossy_hit) begin
          state_d = S_FILL;
        end else if (tb_ok) begin
          state_d = S_MUL_C;
        end else begin
          state_d = S_PSUM;
        end
      end
      S_MUL_C:  state_d = S_MUL_B;
      S_MUL_B:  state_d = S_ADD;
      S_ADD:    state_d = S_DIV_GO;
      S_DIV_GO: state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_d = S_PSUM;
        end
      end
      S_PSUM:   state_d = S_FIX;
      S_FIX:    state_d = S_DIFF;
      S_DIFF:   state_d = S_CMP10;
      S_CMP10:  state_d = S_CMP100;
      S_CMP100: state_d = S_NEXT;
      S_NEXT:   state_d = S_WRB;
      S_WRB:    state_d = S_FILL;
      S_FILL:   state_d = S_OUT;
      S_OUT: begin
        if (m_xfer) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    div_start       = 1'b0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        ram_re          = s_axis_tvalid_i;
      end
      S_DIV_GO: div_start       = 1'b1;
      S_WRB:    ram_we          = 1'b1;
      S_OUT:    m_axis_tvalid_o = 1'b1;
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      lossy_q       <= '0;
      entry_valid_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        lossy_q <= cfg_wdata_i;
      end
      // reset item drops the stream record; a write-back makes it live
      if (s_xfer && in_op == OP_RESET && in_tracked) begin
        entry_valid_q[in_sidx] <= 1'b0;
      end else if (state_q == S_WRB) begin
        entry_valid_q[sidx_q] <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output fill applied to every packet going to a valid sink
  // --------------------------------------------------------------------------
  logic [TS_W-1:0] fill_pts, fill_dts;
  logic            fill_pv, fill_dv;

  always_comb begin
    fill_pts = pts_q;
    fill_dts = dts_q;
    fill_pv  = pv_q;
    fill_dv  = dv_q;
    if (sink_q inside {SINK_SEGMENT, SINK_FILE}) begin
      if (!pv_q && dv_q) begin
        fill_pts = dts_q;
        fill_pv  = 1'b1;
      end else if (pv_q && !dv_q) begin
        fill_dts = pts_q;
        fill_dv  = 1'b1;
      end else if (!pv_q && !dv_q) begin
        fill_pts = START_STAMP;
        fill_dts = START_STAMP;
        fill_pv  = 1'b1;
        fill_dv  = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (s_xfer) begin
          sid_q      <= in_sid;
          sidx_q     <= in_sidx;
          tracked_q  <= in_tracked;
          pts_q      <= s_axis_tdata_i[63:0];
          pv_q       <= s_axis_tdata_i[64];
          dts_q      <= s_axis_tdata_i[128:65];
          dv_q       <= s_axis_tdata_i[129];
          tbn_q      <= s_axis_tdata_i[160:130];
          tbd_q      <= s_axis_tdata_i[191:161];
          rn_q       <= s_axis_tdata_i[222:192];
          rd_q       <= s_axis_tdata_i[253:223];
          sink_q     <= s_axis_tuser_i[6:5];
          seen_q     <= 1'b0;
          snap_q     <= 1'b0;
          // reset item answers with an all-zero result
          o_pts_q    <= '0;
          o_dts_q    <= '0;
          o_seen_q   <= 1'b0;
          o_snap_q   <= 1'b0;
          o_total_q  <= '0;
          o_bad_q    <= 1'b0;
        end
      end
      S_LOAD: begin
        prev_q     <= rec.prev_pts;
        guess_q    <= rec.guess;
        gv_q       <= rec.guess_valid;
        jcnt_q     <= rec.jump_cnt;
        pvalid_q   <= rec_valid;
        dur_full_q <= tb_ok && (rn_q != '0) && (rd_q != '0);
        fd_q       <= DEFAULT_DURATION;
      end
      S_MUL_C: begin
        den_q <= mul_p;
      end
      S_MUL_B: begin
        num_q <= dur_full_q ? DIVN_W'(mul_p) : DIVN_W'(tbd_q);
      end
      S_ADD: begin
        // round half up on the full ratio
        if (dur_full_q) begin
          num_q <= num_q + DIVN_W'(den_q >> 1);
        end
      end
      S_DIV: begin
        if (div_done) begin
          fd_q <= (div_quot == '0) ? DEFAULT_DURATION : DUR_W'(div_quot);
        end
      end
      S_PSUM: begin
        psum_q <= sat_sum;
      end
      S_FIX: begin
        // fill missing stamps, or make them up from the last PTS or the start stamp
        if (!pv_q && dv_q) begin
          pts_q <= dts_q;
        end else if (pv_q && !dv_q) begin
          dts_q <= pts_q;
        end else if (!pv_q && !dv_q) begin
          pts_q <= pvalid_q ? psum_q : START_STAMP;
          dts_q <= pvalid_q ? psum_q : START_STAMP;
        end
        pv_q    <= 1'b1;
        dv_q    <= 1'b1;
        guess_q <= gv_q ? guess_q : psum_q;
      end
      S_DIFF: begin
        diff_q <= ($signed(pts_q) >= $signed(guess_q)) ? pts_q - guess_q
                                                       : guess_q - pts_q;
        thr_q  <= (THR_W'(fd_q) << 3) + (THR_W'(fd_q) << 1);
      end
      S_CMP10: begin
        seen_q <= pvalid_q && (THR_W'(diff_q) > thr_q);
        thr_q  <= (thr_q << 3) + (thr_q << 1);
      end
      S_CMP100: begin
        if (seen_q) begin
          if (jcnt_q != CNT_MAX) begin
            jcnt_q <= jcnt_q + CNT_W'(1);
          end
          if (THR_W'(diff_q) > thr_q) begin
            snap_q <= 1'b1;
            pts_q  <= guess_q;
            dts_q  <= guess_q;
          end
        end
      end
      S_NEXT: begin
        psum_q <= sat_sum;  // next expected PTS
      end
      S_FILL: begin
        o_pts_q   <= fill_pv ? fill_pts : '0;
        o_dts_q   <= fill_dv ? fill_dts : '0;
        o_seen_q  <= seen_q;
        o_snap_q  <= snap_q;
        o_total_q <= tracked_q ? jcnt_q : '0;
        o_bad_q   <= !(sink_q inside {SINK_SEGMENT, SINK_FILE});
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tdata_o = {5'b0, o_bad_q, o_total_q, o_snap_q, o_seen_q, o_dts_q, o_pts_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input taken while a result is pending");

  a_snap_needs_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && o_snap_q |-> o_seen_q)
    else $error("snap reported without a jump");

  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> state_q == S_DIV)
    else $error("divider running outside its wait state");

  a_reset_item_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && in_op == OP_RESET |=> state_q == S_OUT && o_total_q == '0)
    else $error("reset item did not answer at once with zero");

  a_write_after_lossy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> lossy_hit && pv_q && dv_q)
    else $error("record written for a packet that was not repaired");

endmodule

`default_nettype wire
